@@ hdl/rrc_pkg.sv @@
// ---------------------------------------------------------------------------
// rrc_pkg: shared types for the resize rectangle clamp unit
// Payload structs, operation and register codes, coordinate and APB widths.
// ---------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

	localparam int COORD_BITS = 16;             // signed coordinate width
	localparam int UW         = COORD_BITS - 1; // unsigned size width
	localparam int SW         = COORD_BITS + 2; // width of intermediate sums
	localparam int PDATA_W    = 32;             // APB data width
	localparam int PADDR_W    = 4;              // four registers, byte addressed

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_BEGIN  = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_MIN_W  = 2'd0,
		REG_MIN_H  = 2'd1,
		REG_AREA_W = 2'd2,
		REG_AREA_H = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t                          operation;
		logic signed [COORD_BITS-1:0] mouse_px;
		logic signed [COORD_BITS-1:0] mouse_py;
		logic signed [COORD_BITS-1:0] anchor_px;
		logic signed [COORD_BITS-1:0] anchor_py;
		logic signed [COORD_BITS-1:0] orig_left;
		logic signed [COORD_BITS-1:0] orig_top;
		logic        [UW-1:0]         orig_w;
		logic        [UW-1:0]         orig_h;
		logic        [3:0]            edge_mask;
	} req_t;

	typedef struct packed {
		logic                         erase_valid;
		logic signed [COORD_BITS-1:0] erase_left;
		logic signed [COORD_BITS-1:0] erase_top;
		logic        [UW-1:0]         erase_w;
		logic        [UW-1:0]         erase_h;
		logic                         draw_valid;
		logic        [UW-1:0]         draw_left;
		logic        [UW-1:0]         draw_top;
		logic        [UW-1:0]         draw_w;
		logic        [UW-1:0]         draw_h;
	} rsp_t;

endpackage

`default_nettype wire

@@ hdl/resize_rect_clamp_unit.sv @@
// ---------------------------------------------------------------------------
// resize_rect_clamp_unit: resize preview tracker
// Works out the dragged, clamped rectangle and the outlines to erase/draw.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one update, begin or clear
//   item per transfer; rsp channel (rsp_valid/rsp_ready/rsp) returns exactly
//   one result per item, in order.
//   The APB port holds min_w, min_h, area_w, area_h at byte addresses 0, 4,
//   8 and 12; write them only while no item is in flight.
//   An accepted item is loaded into the input register; its result is then
//   registered in the result register and offered on the rsp channel.
//   Throughput: one item per cycle while rsp_ready is high. The geometry, the
//   clamp chain and the compare with the shown outline all sit between the
//   input register and the result register, and the shown outline is updated
//   at the same edge that loads the result, so the next item sees it at once.
//   Stall: while rsp_ready is low the result holds; one more item may wait
//   in the input register, then req_ready drops.
//   Reset: both stages empty, nothing shown, registers at 1, 1, 1024, 768.
// ---------------------------------------------------------------------------
`default_nettype none

module resize_rect_clamp_unit
	import rrc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item channel
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire req_t               req,
	// result channel
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rsp_t                    rsp,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	// ---------------- configuration registers ----------------
	logic [UW-1:0] min_w_q, min_h_q, area_w_q, area_h_q;
	reg_idx_t      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_w_q  <= UW'(1);
			min_h_q  <= UW'(1);
			area_w_q <= UW'(1024);
			area_h_q <= UW'(768);
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MIN_W:  min_w_q  <= pwdata[UW-1:0];
				REG_MIN_H:  min_h_q  <= pwdata[UW-1:0];
				REG_AREA_W: area_w_q <= pwdata[UW-1:0];
				REG_AREA_H: area_h_q <= pwdata[UW-1:0];
				default:    min_w_q  <= min_w_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_W:  prdata = PDATA_W'(min_w_q);
			REG_MIN_H:  prdata = PDATA_W'(min_h_q);
			REG_AREA_W: prdata = PDATA_W'(area_w_q);
			REG_AREA_H: prdata = PDATA_W'(area_h_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------- handshake and input register ----------------
	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic out_free;   // result register can take a new result this cycle
	logic move_s1;    // item in the input register transfers to the result

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign move_s1   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// payload needs no reset; load only on a transfer
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// ---------------- shown outline state ----------------
	logic signed [COORD_BITS-1:0] shown_left_q, shown_top_q;
	logic        [UW-1:0]         shown_w_q, shown_h_q;
	logic                         shown_flag_q;

	// ---------------- rectangle geometry ----------------
	// Saturate an intermediate sum into 0..2^UW-1.
	function automatic logic [UW-1:0] sat_u(input logic signed [SW-1:0] v);
		logic [UW-1:0] res;
		if (v[SW-1]) begin
			res = '0;
		end else if (v[SW-2:UW] != '0) begin
			res = '1;
		end else begin
			res = v[UW-1:0];
		end
		return res;
	endfunction

	logic signed [SW-1:0] dx, dy, x, y, r, b, mnw, mnh, aw, ah;
	logic        [UW-1:0] new_left, new_top, new_w, new_h;
	logic        [3:0]    em;

	always_comb begin
		em  = req_s1.edge_mask;
		mnw = SW'(min_w_q);
		mnh = SW'(min_h_q);
		aw  = SW'(area_w_q);
		ah  = SW'(area_h_q);
		dx  = SW'(req_s1.mouse_px) - SW'(req_s1.anchor_px);
		dy  = SW'(req_s1.mouse_py) - SW'(req_s1.anchor_py);
		x   = SW'(req_s1.orig_left);
		y   = SW'(req_s1.orig_top);
		r   = x + SW'(req_s1.orig_w);
		b   = y + SW'(req_s1.orig_h);

		// move dragged edges by the mouse delta
		if (em[0]) x = x + dx;
		if (em[1]) r = r + dx;
		if (em[2]) y = y + dy;
		if (em[3]) b = b + dy;

		// collapse inverted spans
		if (r < x) x = r;
		if (b < y) y = b;

		// clamp to the work area
		if (x < 0) x = '0;
		if (y < 0) y = '0;
		if (r > aw) r = aw;
		if (b > ah) b = ah;

		// enforce the minimum size, growing away from the dragged edge
		if (r < x + mnw) begin
			if (em[0]) begin
				x = r - mnw;
				if (x < 0) begin
					x = '0;
					r = mnw;
				end
			end else begin
				r = x + mnw;
			end
		end
		if (b < y + mnh) begin
			if (em[2]) begin
				y = b - mnh;
				if (y < 0) begin
					y = '0;
					b = mnh;
				end
			end else begin
				b = y + mnh;
			end
		end
		if (r > aw) r = aw;
		if (b > ah) b = ah;

		new_w    = sat_u(r - x);
		new_h    = sat_u(b - y);
		new_left = sat_u(x);
		new_top  = sat_u(y);
	end

	// ---------------- result and next state ----------------
	logic                         same_rect;
	rsp_t                         rsp_d;
	logic signed [COORD_BITS-1:0] shown_left_d, shown_top_d;
	logic        [UW-1:0]         shown_w_d, shown_h_d;
	logic                         shown_flag_d;

	assign same_rect = shown_flag_q
		&& (shown_left_q == $signed({1'b0, new_left}))
		&& (shown_top_q == $signed({1'b0, new_top}))
		&& (shown_w_q == new_w) && (shown_h_q == new_h);

	always_comb begin
		rsp_d        = '0;
		shown_left_d = shown_left_q;
		shown_top_d  = shown_top_q;
		shown_w_d    = shown_w_q;
		shown_h_d    = shown_h_q;
		shown_flag_d = shown_flag_q;
		case (req_s1.operation)
			OP_BEGIN: begin
				// load the start rectangle, nothing on screen yet
				shown_left_d = req_s1.orig_left;
				shown_top_d  = req_s1.orig_top;
				shown_w_d    = req_s1.orig_w;
				shown_h_d    = req_s1.orig_h;
				shown_flag_d = 1'b0;
			end
			OP_CLEAR: begin
				if (shown_flag_q) begin
					rsp_d.erase_valid = 1'b1;
					rsp_d.erase_left  = shown_left_q;
					rsp_d.erase_top   = shown_top_q;
					rsp_d.erase_w     = shown_w_q;
					rsp_d.erase_h     = shown_h_q;
					shown_flag_d      = 1'b0;
				end
			end
			OP_UPDATE: begin
				// redraw only on a change or when nothing is shown
				if (!same_rect) begin
					if (shown_flag_q) begin
						rsp_d.erase_valid = 1'b1;
						rsp_d.erase_left  = shown_left_q;
						rsp_d.erase_top   = shown_top_q;
						rsp_d.erase_w     = shown_w_q;
						rsp_d.erase_h     = shown_h_q;
					end
					rsp_d.draw_valid = 1'b1;
					rsp_d.draw_left  = new_left;
					rsp_d.draw_top   = new_top;
					rsp_d.draw_w     = new_w;
					rsp_d.draw_h     = new_h;
					shown_left_d     = $signed({1'b0, new_left});
					shown_top_d      = $signed({1'b0, new_top});
					shown_w_d        = new_w;
					shown_h_d        = new_h;
					shown_flag_d     = 1'b1;
				end
			end
			default: begin
				// unused code: empty result, hold state
				rsp_d = '0;
			end
		endcase
	end

	// update state at the edge that loads the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_left_q <= '0;
			shown_top_q  <= '0;
			shown_w_q    <= '0;
			shown_h_q    <= '0;
			shown_flag_q <= 1'b0;
		end else if (move_s1) begin
			shown_left_q <= shown_left_d;
			shown_top_q  <= shown_top_d;
			shown_w_q    <= shown_w_d;
			shown_h_q    <= shown_h_d;
			shown_flag_q <= shown_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	// a pending draw result matches the outline now recorded as shown
	a_draw_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.draw_valid |->
			shown_flag_q && shown_w_q == rsp_q.draw_w && shown_h_q == rsp_q.draw_h
			&& shown_left_q == $signed({1'b0, rsp_q.draw_left}))
		else $error("draw result disagrees with shown outline");

	// an erase without a draw comes from a clear, which leaves nothing shown
	a_clear_drops_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.erase_valid && !rsp_q.draw_valid |-> !shown_flag_q)
		else $error("shown flag still set after clear");

	// state must not advance while a result is stalled
	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> $stable(shown_flag_q) && $stable(shown_w_q))
		else $error("shown state changed under a stalled result");

	// an accepted item always lands in the input register
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> valid_s1)
		else $error("accepted item lost");

endmodule

`default_nettype wire

@@ bench/resize_rect_clamp_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// resize_rect_clamp_unit_tb: self-checking bench for the resize preview unit
// Drives drag gestures, clears and random events through the item channel.
// Each transfer is run through a bit-accurate model of the drag, the
// area/minimum-size clamp and the shown-outline tracking. Results are checked
// in order, field by field. The size registers are reprogrammed over the
// APB port between phases, including their extremes.
// ---------------------------------------------------------------------------

module resize_rect_clamp_unit_tb;
	import rrc_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 250;

	typedef logic signed [SW-1:0] sum_t;
	localparam sum_t MAX_SIZE = (1 << UW) - 1;

	// DUT connections; every driven input starts at a known value
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Register mirror, starts at the reset values
	logic [UW-1:0] cfg_min_w  = 1;
	logic [UW-1:0] cfg_min_h  = 1;
	logic [UW-1:0] cfg_area_w = 1024;
	logic [UW-1:0] cfg_area_h = 768;

	// Outline the unit believes is on screen
	logic signed [COORD_BITS-1:0] shown_left = '0;
	logic signed [COORD_BITS-1:0] shown_top  = '0;
	logic        [UW-1:0]         shown_w    = '0;
	logic        [UW-1:0]         shown_h    = '0;
	logic                         shown_flag = 1'b0;

	req_t drag_events [$];   // events waiting to be sent
	rsp_t due_outlines [$];  // predicted erase/draw results, oldest first

	int send_gap       = 0;
	int stall_left     = 0;
	int sent_count     = 0;
	int fail_count     = 0;
	int cycle_count    = 0;
	bit offer          = 1'b0;
	bit wait_for_drain = 1'b0;
	bit calm_sender    = 1'b0;
	bit calm_receiver  = 1'b0;

	resize_rect_clamp_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Model of the unit
	// -----------------------------------------------------------------------

	// Saturate a sum to the unsigned size range; negatives become zero.
	function automatic logic [UW-1:0] clip_size(sum_t v);
		if (v < 0)
			return '0;
		if (v > MAX_SIZE)
			return '1;
		return v[UW-1:0];
	endfunction

	// Apply one event to the shown-outline state and return its result.
	function automatic rsp_t predict_outline(req_t it);
		rsp_t          res;
		sum_t          dx, dy, x, y, r, b, mnw, mnh, aw, ah;
		logic [UW-1:0] nx, ny, nw, nh;
		res = '0;
		mnw = sum_t'({1'b0, cfg_min_w});
		mnh = sum_t'({1'b0, cfg_min_h});
		aw  = sum_t'({1'b0, cfg_area_w});
		ah  = sum_t'({1'b0, cfg_area_h});
		case (it.operation)
		OP_BEGIN: begin
			// load the start rectangle, nothing on screen yet
			shown_left = it.orig_left;
			shown_top  = it.orig_top;
			shown_w    = it.orig_w;
			shown_h    = it.orig_h;
			shown_flag = 1'b0;
		end
		OP_CLEAR: begin
			if (shown_flag) begin
				res.erase_valid = 1'b1;
				res.erase_left  = shown_left;
				res.erase_top   = shown_top;
				res.erase_w     = shown_w;
				res.erase_h     = shown_h;
				shown_flag      = 1'b0;
			end
		end
		OP_UPDATE: begin
			dx = sum_t'($signed(it.mouse_px)) - sum_t'($signed(it.anchor_px));
			dy = sum_t'($signed(it.mouse_py)) - sum_t'($signed(it.anchor_py));
			x  = sum_t'($signed(it.orig_left));
			y  = sum_t'($signed(it.orig_top));
			r  = x + sum_t'({1'b0, it.orig_w});
			b  = y + sum_t'({1'b0, it.orig_h});
			if (it.edge_mask[0]) x = x + dx;
			if (it.edge_mask[1]) r = r + dx;
			if (it.edge_mask[2]) y = y + dy;
			if (it.edge_mask[3]) b = b + dy;
			// collapse inverted spans
			if (r < x) x = r;
			if (b < y) y = b;
			// clamp to the work area
			if (x < 0) x = 0;
			if (y < 0) y = 0;
			if (r > aw) r = aw;
			if (b > ah) b = ah;
			// grow to the minimum size, away from the dragged edge
			if (r < x + mnw) begin
				if (it.edge_mask[0]) begin
					x = r - mnw;
					if (x < 0) begin
						x = 0;
						r = mnw;
					end
				end else begin
					r = x + mnw;
				end
			end
			if (b < y + mnh) begin
				if (it.edge_mask[2]) begin
					y = b - mnh;
					if (y < 0) begin
						y = 0;
						b = mnh;
					end
				end else begin
					b = y + mnh;
				end
			end
			if (r > aw) r = aw;
			if (b > ah) b = ah;
			nw = clip_size(r - x);
			nh = clip_size(b - y);
			nx = clip_size(x);
			ny = clip_size(y);
			// same outline already on screen: nothing to do
			if (!(shown_flag && {1'b0, nx} == shown_left && {1'b0, ny} == shown_top &&
					nw == shown_w && nh == shown_h)) begin
				if (shown_flag) begin
					res.erase_valid = 1'b1;
					res.erase_left  = shown_left;
					res.erase_top   = shown_top;
					res.erase_w     = shown_w;
					res.erase_h     = shown_h;
				end
				res.draw_valid = 1'b1;
				res.draw_left  = nx;
				res.draw_top   = ny;
				res.draw_w     = nw;
				res.draw_h     = nh;
				shown_left     = {1'b0, nx};
				shown_top      = {1'b0, ny};
				shown_w        = nw;
				shown_h        = nh;
				shown_flag     = 1'b1;
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Item channel driver
	// -----------------------------------------------------------------------

	// Idle length: mostly none or short, now and then long.
	function automatic int draw_gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap       = 0;
			wait_for_drain = 1'b0;
		end else begin
			offer = req_valid;
			if (req_valid && req_ready) begin
				// predict at the transfer, with the payload that was held
				due_outlines.push_back(predict_outline(req));
				offer      = 1'b0;
				sent_count = sent_count + 1;
				send_gap   = calm_sender ? 0 : draw_gap_len();
				// every so often hold off until the unit has drained
				wait_for_drain = (sent_count % 97 == 50) || ($urandom_range(0, 59) == 0);
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
				end else if (drag_events.size() != 0 &&
						(!wait_for_drain || due_outlines.size() == 0)) begin
					req <= drag_events.pop_front();
					offer = 1'b1;
				end
			end
			// one assignment per edge keeps valid high across back-to-back items
			req_valid <= offer;
		end
	end

	// -----------------------------------------------------------------------
	// Result channel monitor
	// -----------------------------------------------------------------------

	task automatic check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count = fail_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_outlines.size() == 0) begin
					$error("result transfer with no event outstanding");
					fail_count = fail_count + 1;
				end else begin
					check_field("erase_valid", due_outlines[0].erase_valid, rsp.erase_valid);
					check_field("erase_left",  due_outlines[0].erase_left,  rsp.erase_left);
					check_field("erase_top",   due_outlines[0].erase_top,   rsp.erase_top);
					check_field("erase_w",     due_outlines[0].erase_w,     rsp.erase_w);
					check_field("erase_h",     due_outlines[0].erase_h,     rsp.erase_h);
					check_field("draw_valid",  due_outlines[0].draw_valid,  rsp.draw_valid);
					check_field("draw_left",   due_outlines[0].draw_left,   rsp.draw_left);
					check_field("draw_top",    due_outlines[0].draw_top,    rsp.draw_top);
					check_field("draw_w",      due_outlines[0].draw_w,      rsp.draw_w);
					check_field("draw_h",      due_outlines[0].draw_h,      rsp.draw_h);
					void'(due_outlines.pop_front());
				end
			end
			// back-pressure: random stalls, none during calm phases
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				stall_left = calm_receiver ? 0 : draw_gap_len();
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[resize_rect_clamp_unit] ERROR");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------

	// Write one size register: setup phase, then access phase.
	task automatic write_reg(reg_idx_t idx, logic [UW-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
		REG_MIN_W:  cfg_min_w  = val;
		REG_MIN_H:  cfg_min_h  = val;
		REG_AREA_W: cfg_area_w = val;
		REG_AREA_H: cfg_area_h = val;
		default: ;
		endcase
		@(negedge clk);
	endtask

	// Hold until every queued event is sent and every result has come back.
	task automatic wait_drained();
		while (drag_events.size() != 0 || req_valid || due_outlines.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic req_t make_event(op_t op, int mx, int my, int ax, int ay,
			int l, int t, int w, int h, logic [3:0] mask);
		req_t it;
		it.operation = op;
		it.mouse_px  = COORD_BITS'(mx);
		it.mouse_py  = COORD_BITS'(my);
		it.anchor_px = COORD_BITS'(ax);
		it.anchor_py = COORD_BITS'(ay);
		it.orig_left = COORD_BITS'(l);
		it.orig_top  = COORD_BITS'(t);
		it.orig_w    = UW'(w);
		it.orig_h    = UW'(h);
		it.edge_mask = mask;
		return it;
	endfunction

	// Coordinate: mostly near the work area, sometimes anywhere or at a rail.
	function automatic logic signed [COORD_BITS-1:0] pick_coord(int span);
		logic signed [COORD_BITS-1:0] v;
		case ($urandom_range(0, 9))
		0, 1: v = COORD_BITS'($urandom);
		2: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		default: v = COORD_BITS'(int'($urandom_range(0, span + span / 4)) - span / 8);
		endcase
		return v;
	endfunction

	function automatic logic [UW-1:0] pick_size(int span);
		logic [UW-1:0] v;
		case ($urandom_range(0, 7))
		0: v = '0;
		1: v = '1;
		2, 3: v = UW'($urandom);
		default: v = UW'($urandom_range(0, span / 2 + 1));
		endcase
		return v;
	endfunction

	// One drag: begin, a run of mouse moves, usually a clear at the end.
	task automatic queue_drag_gesture();
		req_t                         it;
		logic signed [COORD_BITS-1:0] mx, my;
		int                           steps;
		it           = '0;
		it.operation = OP_BEGIN;
		it.orig_left = pick_coord(cfg_area_w);
		it.orig_top  = pick_coord(cfg_area_h);
		it.orig_w    = pick_size(cfg_area_w);
		it.orig_h    = pick_size(cfg_area_h);
		it.mouse_px  = COORD_BITS'($urandom);
		it.mouse_py  = COORD_BITS'($urandom);
		drag_events.push_back(it);
		it.operation = OP_UPDATE;
		it.anchor_px = pick_coord(cfg_area_w);
		it.anchor_py = pick_coord(cfg_area_h);
		it.edge_mask = 4'($urandom_range(0, 15));
		mx    = it.anchor_px;
		my    = it.anchor_py;
		steps = $urandom_range(1, 12);
		repeat (steps) begin
			case ($urandom_range(0, 9))
			0: ; // mouse held still: same outline again
			1: begin
				mx = pick_coord(cfg_area_w);
				my = pick_coord(cfg_area_h);
			end
			default: begin
				mx = mx + COORD_BITS'(int'($urandom_range(0, 40)) - 20);
				my = my + COORD_BITS'(int'($urandom_range(0, 40)) - 20);
			end
			endcase
			it.mouse_px = mx;
			it.mouse_py = my;
			if ($urandom_range(0, 15) == 0)
				it.edge_mask = 4'($urandom_range(0, 15));
			drag_events.push_back(it);
		end
		if ($urandom_range(0, 3) != 0) begin
			it.operation = OP_CLEAR;
			drag_events.push_back(it);
		end
	endtask

	// Arbitrary event, any operation, any field value.
	task automatic queue_noise_event();
		req_t it;
		it           = req_t'({$urandom, $urandom, $urandom, $urandom, 4'($urandom)});
		it.operation = op_t'($urandom_range(0, 2));
		drag_events.push_back(it);
	endtask

	int phase_cfg [PHASES][4] = '{
		'{1, 1, 1024, 768},        // reset values, not written
		'{0, 0, 32767, 32767},     // no minimum, largest area
		'{32767, 32767, 1, 1},     // minimum far beyond a one-pixel area
		'{20, 10, 640, 480},
		'{32767, 32767, 32767, 32767},
		'{0, 0, 0, 0},             // drawn at random below
		'{1, 1, 1024, 768}
	};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed events with the reset register values (area 1024 x 768)
		drag_events.push_back(make_event(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, 100, 50, 200, 100, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, 100, 50, 200, 100, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 30, 0, 0, 0, 100, 50, 200, 100, 4'h2));
		drag_events.push_back(make_event(OP_UPDATE, 10, 20, 0, 0, 100, 50, 200, 100, 4'h1));
		drag_events.push_back(make_event(OP_UPDATE, 10, 20, 0, 0, 100, 50, 200, 100, 4'h4));
		drag_events.push_back(make_event(OP_UPDATE, 10, 20, 0, 0, 100, 50, 200, 100, 4'h8));
		drag_events.push_back(make_event(OP_UPDATE, 32767, 32767, -32768, -32768,
			100, 50, 200, 100, 4'hf));
		drag_events.push_back(make_event(OP_UPDATE, -32768, -32768, 32767, 32767,
			100, 50, 200, 100, 4'hf));
		// left edge dragged past the right one, then top past bottom
		drag_events.push_back(make_event(OP_UPDATE, 500, 0, 0, 0, 100, 50, 200, 100, 4'h1));
		drag_events.push_back(make_event(OP_UPDATE, 0, 400, 0, 0, 100, 50, 200, 100, 4'h4));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, 1020, 760, 32767, 32767, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, 1024, 768, 0, 0, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, -32768, -32768,
			32767, 32767, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, 32767, 32767, 0, 0, 4'h5));
		drag_events.push_back(make_event(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0));
		drag_events.push_back(make_event(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0));
		drag_events.push_back(make_event(OP_BEGIN, 0, 0, 0, 0, -32768, 32767, 32767, 0, 4'h0));
		drag_events.push_back(make_event(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0));
		drag_events.push_back(make_event(OP_BEGIN, 0, 0, 0, 0, 100, 50, 200, 100, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, 100, 50, 200, 100, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 7, -3, 0, 0, 100, 50, 200, 100, 4'hf));
		drag_events.push_back(make_event(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0));
		drag_events.push_back(make_event(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0));
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				if (phase == 5) begin
					phase_cfg[phase][0] = $urandom_range(0, 64);
					phase_cfg[phase][1] = $urandom_range(0, 64);
					phase_cfg[phase][2] = $urandom_range(16, 2048);
					phase_cfg[phase][3] = $urandom_range(16, 2048);
				end
				write_reg(REG_MIN_W,  UW'(phase_cfg[phase][0]));
				write_reg(REG_MIN_H,  UW'(phase_cfg[phase][1]));
				write_reg(REG_AREA_W, UW'(phase_cfg[phase][2]));
				write_reg(REG_AREA_H, UW'(phase_cfg[phase][3]));
			end
			// phase 3 runs with no random gaps or stalls on either side, phase 6 with none on the result side
			calm_sender   = (phase == 3);
			calm_receiver = (phase == 3) || (phase == 6);
			while (drag_events.size() < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0)
					queue_noise_event();
				else
					queue_drag_gesture();
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("[resize_rect_clamp_unit] OK");
		end else begin
			$display("[resize_rect_clamp_unit] ERROR");
		end
		$finish;
	end

endmodule
